// ===== sv/frs_pkg.sv =====
// Shared types and constants for the forward route select unit.
package frs_pkg;

	localparam int unsigned SECONDS_PER_DAY = 86400;
	localparam logic [32:0] DELAY_TOLERANCE = 33'd300;
	localparam logic [15:0] HOPS_START      = 16'd1000;
	localparam logic [15:0] MIN_MAILS       = 16'd2;

	// One neighbor entry as it sits in the input register.
	typedef struct packed {
		logic [31:0] now_time;
		logic        entry_present;
		logic        is_partner;
		logic [15:0] mail_count;
		logic [31:0] last_update;
		logic [31:0] path_delay;
		logic [15:0] hop_count;
	} entry_t;

	// Running selection state of the current record.
	typedef struct packed {
		logic [31:0] age_cutoff;
		logic [32:0] delay_limit;
		logic [15:0] best_hops;
		logic [31:0] best_update;
		logic [2:0]  chosen_slot;
		logic        have_choice;
	} sel_state_t;

	// Slot information handed from the counter to the judge.
	typedef struct packed {
		logic       start;
		logic       in_range;
		logic [2:0] slot;
	} slot_info_t;

endpackage

// ===== sv/frs_judge.sv =====
// Judges one neighbor entry against the running best and forms the next selection state.
module frs_judge (
	input  frs_pkg::entry_t     entry,
	input  frs_pkg::slot_info_t slot_info,
	input  frs_pkg::sel_state_t cur,
	input  logic [32:0]         age_span,
	output frs_pkg::sel_state_t nxt
);

	frs_pkg::sel_state_t base;
	logic                qualify;

	// At record start the state is seeded from this entry's now_time.
	always_comb begin
		base = cur;
		if (slot_info.start) begin
			if (age_span >= {1'b0, entry.now_time}) begin
				base.age_cutoff = 32'd0;
			end else begin
				base.age_cutoff = entry.now_time - age_span[31:0];
			end
			base.delay_limit = {1'b0, entry.now_time};
			base.best_hops   = frs_pkg::HOPS_START;
			base.best_update = 32'd0;
			base.chosen_slot = 3'd0;
			base.have_choice = 1'b0;
		end
	end

	always_comb begin
		qualify = slot_info.in_range
			&& entry.entry_present
			&& entry.is_partner
			&& (entry.mail_count > frs_pkg::MIN_MAILS)
			&& (entry.last_update > base.age_cutoff)
			&& ({1'b0, entry.path_delay} < base.delay_limit)
			&& ((entry.hop_count < base.best_hops)
				|| ((entry.hop_count == base.best_hops)
					&& (entry.last_update > base.best_update)));
	end

	always_comb begin
		nxt = base;
		if (qualify) begin
			nxt.best_update = entry.last_update;
			nxt.delay_limit = {1'b0, entry.path_delay} + frs_pkg::DELAY_TOLERANCE;
			nxt.best_hops   = entry.hop_count;
			nxt.chosen_slot = slot_info.slot;
			nxt.have_choice = 1'b1;
		end
	end

endmodule

// ===== sv/forward_route_select_unit.sv =====
// Top level of the forward route select unit: input register, selection state, result register.
//
// Neighbor entries of a routing record stream in one per transfer, last_entry closing the
// record; one result (found, best_index) comes out for each record, in the cycle after the
// closing entry is judged. An entry is held in the input register and entries are
// taken back to back, one per cycle; the input side stalls only when a closing entry meets a
// result still held by a stalled output. The age window is multiplied out into seconds when
// max_age_days is written, so the per-entry path is one subtract, one add and compares. Entries
// beyond MAX_NEIGHBORS in a record are ignored, but their last_entry still closes the record.
module forward_route_select_unit #(
	parameter int unsigned MAX_NEIGHBORS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] now_time,
	input  logic        entry_present,
	input  logic        is_partner,
	input  logic [15:0] mail_count,
	input  logic [31:0] last_update,
	input  logic [31:0] path_delay,
	input  logic [15:0] hop_count,
	input  logic        last_entry,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [2:0]  best_index
);

	localparam int unsigned CW = $clog2(MAX_NEIGHBORS + 1);
	localparam logic [CW-1:0] SLOT_MAX = CW'(MAX_NEIGHBORS);

	logic [32:0]          age_span_q;
	logic [CW-1:0]        slot_cnt_q;
	frs_pkg::sel_state_t  state_q;
	frs_pkg::sel_state_t  state_nxt;
	frs_pkg::slot_info_t  slot_info;
	logic [CW+2:0]        slot_ext;

	logic                 valid_s1;
	frs_pkg::entry_t      entry_s1;
	logic                 last_s1;

	logic                 out_valid_q;
	logic                 found_q;
	logic [2:0]           best_index_q;

	logic                 proc;

	// Age window in seconds, formed at the register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_span_q <= 33'd0;
		end else if (cfg_we) begin
			age_span_q <= 33'({17'd0, cfg_wdata} * 33'(frs_pkg::SECONDS_PER_DAY));
		end
	end

	// A closing entry needs the result register free or draining.
	assign proc     = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			entry_s1.now_time      <= now_time;
			entry_s1.entry_present <= entry_present;
			entry_s1.is_partner    <= is_partner;
			entry_s1.mail_count    <= mail_count;
			entry_s1.last_update   <= last_update;
			entry_s1.path_delay    <= path_delay;
			entry_s1.hop_count     <= hop_count;
			last_s1                <= last_entry;
		end
	end

	assign slot_ext           = {3'd0, slot_cnt_q};
	assign slot_info.start    = (slot_cnt_q == '0);
	assign slot_info.in_range = (slot_cnt_q < SLOT_MAX);
	assign slot_info.slot     = slot_ext[2:0];

	frs_judge u_judge (
		.entry     (entry_s1),
		.slot_info (slot_info),
		.cur       (state_q),
		.age_span  (age_span_q),
		.nxt       (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_cnt_q <= '0;
			state_q    <= '0;
		end else if (proc) begin
			state_q <= state_nxt;
			if (last_s1) begin
				slot_cnt_q <= '0;
			end else if (slot_info.in_range) begin
				slot_cnt_q <= slot_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1) begin
			found_q      <= state_nxt.have_choice;
			best_index_q <= state_nxt.have_choice ? state_nxt.chosen_slot : 3'd0;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign best_index = best_index_q;

	a_close_gives_result : assert property (@(posedge clk) disable iff (!arst_n)
		proc && last_s1 |=> out_valid_q)
		else $error("closing entry produced no result");

	a_not_found_index : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> best_index_q == 3'd0)
		else $error("best_index nonzero on not-found result");

	a_slot_bound : assert property (@(posedge clk) disable iff (!arst_n)
		slot_cnt_q <= SLOT_MAX)
		else $error("slot counter beyond neighbor count");

	a_close_resets_slot : assert property (@(posedge clk) disable iff (!arst_n)
		proc && last_s1 |=> slot_cnt_q == '0)
		else $error("slot counter not cleared after record close");

endmodule
